>>> rtl/triangle_unit_normal_core_defines.svh
// Assertion macros used by the triangle unit normal top level.
`ifndef TRIANGLE_UNIT_NORMAL_CORE_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TUN_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("%m: assertion failed");
`define TUN_ASSERT_IMPL(lbl, ante, cons) \
	`TUN_ASSERT(lbl, (ante) |-> (cons))
`else
`define TUN_ASSERT(lbl, prop)
`define TUN_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> rtl/tun_pkg.sv
// Shared types and default widths for the triangle unit normal pipeline.
`default_nettype none
package tun_pkg;
	localparam int DEF_COORD_WIDTH      = 16;
	localparam int DEF_NORMAL_FRAC_BITS = 14;

	typedef struct packed {
		logic vld;
		logic neg;
		logic degen;
	} tag_t;
endpackage
`default_nettype wire

>>> rtl/tun_front.sv
// Edge vectors, cross product, component squares and sum of squares.
`default_nettype none
module tun_front #(
	parameter int COORD_WIDTH = tun_pkg::DEF_COORD_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_vld,
	input  logic [8:0][COORD_WIDTH-1:0]       crd,
	output logic [2:0][4*COORD_WIDTH+3:0]     sq,
	output logic [4*COORD_WIDTH+5:0]          sum,
	output tun_pkg::tag_t [2:0]               tag
);
	import tun_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int EW = CW + 1;
	localparam int PW = 2 * EW;
	localparam int KW = PW + 1;
	localparam int MW = KW - 1;
	localparam int H  = (MW + 1) / 2;
	localparam int HW = MW - H;
	localparam int QW = 2 * MW;
	localparam int SW = QW + 2;

	logic signed [EW-1:0] e_s1 [3];
	logic signed [EW-1:0] f_s1 [3];
	logic signed [PW-1:0] p_s2 [3];
	logic signed [PW-1:0] q_s2 [3];
	logic signed [KW-1:0] k_s3 [3];
	logic [MW-1:0]        mag_s4 [3];
	logic [2*HW-1:0]      hh_s5 [3];
	logic [HW+H-1:0]      hl_s5 [3];
	logic [2*H-1:0]       ll_s5 [3];
	logic [QW-1:0]        sq_s6 [3];
	logic [QW-1:0]        sq_s7 [3];
	logic [SW-1:0]        sum_s7;
	logic                 neg_s4 [3];
	logic                 neg_s5 [3];
	logic                 neg_s6 [3];
	logic                 neg_s7 [3];
	logic                 degen_s7;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= '0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				e_s1[i]   <= $signed({crd[3+i][CW-1], crd[3+i]}) -
				             $signed({crd[i][CW-1], crd[i]});
				f_s1[i]   <= $signed({crd[6+i][CW-1], crd[6+i]}) -
				             $signed({crd[i][CW-1], crd[i]});
				p_s2[i]   <= e_s1[(i+1)%3] * f_s1[(i+2)%3];
				q_s2[i]   <= e_s1[(i+2)%3] * f_s1[(i+1)%3];
				k_s3[i]   <= KW'(p_s2[i]) - KW'(q_s2[i]);
				mag_s4[i] <= k_s3[i][KW-1] ? MW'(-k_s3[i]) : MW'(k_s3[i]);
				neg_s4[i] <= k_s3[i][KW-1];
				// split the square into half-width partial products
				hh_s5[i]  <= (2*HW)'(mag_s4[i][MW-1:H]) * (2*HW)'(mag_s4[i][MW-1:H]);
				hl_s5[i]  <= (HW+H)'(mag_s4[i][MW-1:H]) * (HW+H)'(mag_s4[i][H-1:0]);
				ll_s5[i]  <= (2*H)'(mag_s4[i][H-1:0]) * (2*H)'(mag_s4[i][H-1:0]);
				neg_s5[i] <= neg_s4[i];
				sq_s6[i]  <= (QW'(hh_s5[i]) << (2*H)) + (QW'(hl_s5[i]) << (H+1)) +
				             QW'(ll_s5[i]);
				neg_s6[i] <= neg_s5[i];
				sq_s7[i]  <= sq_s6[i];
				neg_s7[i] <= neg_s6[i];
			end
		end
		assign sq[i]  = sq_s7[i];
		assign tag[i] = '{vld: vld_s7, neg: neg_s7[i], degen: degen_s7};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s7   <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
			degen_s7 <= (sq_s6[0] == '0) && (sq_s6[1] == '0) && (sq_s6[2] == '0);
		end
	end

	assign sum = sum_s7;
endmodule
`default_nettype wire

>>> rtl/tun_div.sv
// Restoring divider, one quotient bit per stage: floor(num * 2^(Q_W-1) / den).
`default_nettype none
module tun_div #(
	parameter int NUM_W = 68,
	parameter int DEN_W = 70,
	parameter int Q_W   = 31
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [NUM_W-1:0]   num,
	input  logic [DEN_W-1:0]   den,
	input  tun_pkg::tag_t      tag_in,
	output logic [Q_W-1:0]     quo,
	output tun_pkg::tag_t      tag_out
);
	import tun_pkg::*;

	localparam int RW = DEN_W + 1;

	logic [RW-1:0]    rem_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   quo_s [Q_W];
	tag_t             tag_s [Q_W];

	for (genvar g = 0; g < Q_W; g++) begin : g_stage
		logic [RW-1:0]  cand;
		logic [RW-1:0]  dvs;
		logic [Q_W-1:0] qprev;
		tag_t           tprev;
		logic           ge;

		if (g == 0) begin : g_first
			assign cand  = RW'(num);
			assign dvs   = RW'(den);
			assign qprev = '0;
			assign tprev = tag_in;
		end else begin : g_next
			assign cand  = {rem_s[g-1][RW-2:0], 1'b0};
			assign dvs   = RW'(den_s[g-1]);
			assign qprev = quo_s[g-1];
			assign tprev = tag_s[g-1];
		end
		assign ge = cand >= dvs;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[g] <= '0;
			end else if (en) begin
				tag_s[g] <= tprev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= ge ? cand - dvs : cand;
				den_s[g] <= dvs[DEN_W-1:0];
				quo_s[g] <= {qprev[Q_W-2:0], ge};
			end
		end
	end

	assign quo     = quo_s[Q_W-1];
	assign tag_out = tag_s[Q_W-1];
endmodule
`default_nettype wire

>>> rtl/tun_isqrt.sv
// Integer floor square root, one root bit per stage.
`default_nettype none
module tun_isqrt #(
	parameter int IN_W  = 31,
	parameter int ROOT_W = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [IN_W-1:0]     rad,
	input  tun_pkg::tag_t       tag_in,
	output logic [ROOT_W-1:0]   root,
	output tun_pkg::tag_t       tag_out
);
	import tun_pkg::*;

	localparam int DW = 2 * ROOT_W + 1;

	logic [DW-1:0]     rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	tag_t              tag_s  [ROOT_W];

	for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
		localparam int B = ROOT_W - 1 - g;
		logic [DW-1:0]     rprev;
		logic [ROOT_W-1:0] sprev;
		tag_t              tprev;
		logic [DW-1:0]     trial;
		logic              ge;

		if (g == 0) begin : g_first
			assign rprev = DW'(rad);
			assign sprev = '0;
			assign tprev = tag_in;
		end else begin : g_next
			assign rprev = rem_s[g-1];
			assign sprev = root_s[g-1];
			assign tprev = tag_s[g-1];
		end
		// (r + 2^B)^2 - r^2
		assign trial = (DW'(sprev) << (B + 1)) + (DW'(1) << (2 * B));
		assign ge    = rprev >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[g] <= '0;
			end else if (en) begin
				tag_s[g] <= tprev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= ge ? rprev - trial : rprev;
				root_s[g] <= ge ? (sprev | (ROOT_W'(1) << B)) : sprev;
			end
		end
	end

	assign root    = root_s[ROOT_W-1];
	assign tag_out = tag_s[ROOT_W-1];
endmodule
`default_nettype wire

>>> rtl/triangle_unit_normal_core.sv
// Top level of the triangle unit normal pipeline.
`default_nettype none
`include "triangle_unit_normal_core_defines.svh"
// Takes one triangle word per clock and returns its unit face normal in signed
// fixed point (NORMAL_FRAC_BITS fraction bits), rounded to nearest, ties away
// from zero. The pipeline has 2*NORMAL_FRAC_BITS + 3 divider stages, one per
// quotient bit, and NORMAL_FRAC_BITS + 2 square root stages, one per root bit,
// after seven stages of cross product and squaring and before one output
// register, and it takes one word per cycle. The whole pipeline holds while
// the output word waits. A triangle whose cross product is zero gives zero
// components with tuser set.
module triangle_unit_normal_core #(
	parameter int COORD_WIDTH      = tun_pkg::DEF_COORD_WIDTH,
	parameter int NORMAL_FRAC_BITS = tun_pkg::DEF_NORMAL_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	// ax, ay, az, bx, by_coord, bz, cx, cy, cz
	input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]        s_tdata,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// nx, ny, nz
	output logic [((3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
	// degenerate
	output logic                                      m_tuser,
	output logic                                      m_tvalid,
	input  logic                                      m_tready
);
	import tun_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int F     = NORMAL_FRAC_BITS;
	localparam int QW    = 4 * CW + 4;
	localparam int SW    = QW + 2;
	localparam int QB    = 2 * F + 3;
	localparam int RB    = F + 2;
	localparam int OW    = F + 2;
	localparam int OUT_W = ((3 * OW + 7) / 8) * 8;

	logic                       en;
	logic [8:0][CW-1:0]         crd;
	logic [2:0][QW-1:0]         sq;
	logic [SW-1:0]              sum;
	tag_t [2:0]                 fr_tag;
	logic [QB-1:0]              quo [3];
	tag_t                       dv_tag [3];
	logic [RB-1:0]              root [3];
	tag_t                       rt_tag [3];
	logic [OW-1:0]              comp [3];

	// advance everything when the output register is free or being drained
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	for (genvar i = 0; i < 9; i++) begin : g_crd
		assign crd[i] = s_tdata[i*CW +: CW];
	end

	tun_front #(.COORD_WIDTH(CW)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (s_tvalid),
		.crd    (crd),
		.sq     (sq),
		.sum    (sum),
		.tag    (fr_tag)
	);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic [RB:0]   rnd;
		logic [OW-1:0] mag;

		tun_div #(.NUM_W(QW), .DEN_W(SW), .Q_W(QB)) u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.num     (sq[i]),
			.den     (sum),
			.tag_in  (fr_tag[i]),
			.quo     (quo[i]),
			.tag_out (dv_tag[i])
		);

		tun_isqrt #(.IN_W(QB), .ROOT_W(RB)) u_isqrt (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.rad     (quo[i]),
			.tag_in  (dv_tag[i]),
			.root    (root[i]),
			.tag_out (rt_tag[i])
		);

		// root carries one extra bit: add half and drop it
		assign rnd     = (RB + 1)'(root[i]) + (RB + 1)'(1);
		assign mag     = OW'(rnd[RB:1]);
		assign comp[i] = rt_tag[i].degen ? '0 : (rt_tag[i].neg ? -mag : mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= rt_tag[0].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= OUT_W'({comp[2], comp[1], comp[0]});
			m_tuser <= rt_tag[0].degen;
		end
	end

	localparam logic [QB-1:0] QUO_MAX  = QB'(1) << (QB - 1);
	localparam logic [RB-1:0] ROOT_MAX = RB'(1) << (RB - 1);

	`TUN_ASSERT_IMPL(a_degen_zero, m_tvalid && m_tuser, m_tdata == '0)
	`TUN_ASSERT_IMPL(a_quo_bound, dv_tag[0].vld && !dv_tag[0].degen, quo[0] <= QUO_MAX)
	`TUN_ASSERT_IMPL(a_root_bound, rt_tag[0].vld && !rt_tag[0].degen, root[0] <= ROOT_MAX)
	`TUN_ASSERT(a_lane_sync, (fr_tag[0].vld == fr_tag[2].vld) && (rt_tag[1].vld == rt_tag[0].vld))
endmodule
`default_nettype wire

>>> verif/tb_triangle_unit_normal_core.sv
// Testbench for triangle_unit_normal_core: random and directed triangles against a local predictor.
`default_nettype none

typedef struct {
	logic [15:0] nx;
	logic [15:0] ny;
	logic [15:0] nz;
	logic        degen;
} normal_t;

class normal_scoreboard;
	normal_t pending[$];
	int      errors;

	function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
		logic [63:0] rem, root, probe;
		rem = x;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > x) probe >>= 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// Exact cross product, then each component scaled by 2^14 / |k| rounded half away.
	function void note_triangle(input logic [143:0] word);
		logic signed [63:0] v[9];
		logic signed [63:0] e[3], f[3], k[3];
		logic [127:0] mag[3], sum, num, quot;
		logic [63:0] n;
		logic [15:0] comp[3];
		normal_t exp_n;
		for (int i = 0; i < 9; i++) v[i] = 64'(signed'(word[16*i +: 16]));
		for (int i = 0; i < 3; i++) begin
			e[i] = v[3+i] - v[i];
			f[i] = v[6+i] - v[i];
		end
		k[0] = e[1]*f[2] - e[2]*f[1];
		k[1] = e[2]*f[0] - e[0]*f[2];
		k[2] = e[0]*f[1] - e[1]*f[0];
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (k[i] < 0) ? 128'(-k[i]) : 128'(k[i]);
			sum += mag[i] * mag[i];
		end
		for (int i = 0; i < 3; i++) begin
			comp[i] = 0;
			if (sum != 0) begin
				num = (mag[i] * mag[i]) << 30;
				quot = num / sum;
				n = (floor_sqrt(quot[63:0]) + 1) >> 1;
				comp[i] = (k[i] < 0) ? 16'(-n) : 16'(n);
			end
		end
		exp_n.nx = comp[0];
		exp_n.ny = comp[1];
		exp_n.nz = comp[2];
		exp_n.degen = (sum == 0);
		pending.push_back(exp_n);
	endfunction

	function void check_normal(input logic [47:0] data, input logic user);
		normal_t exp_n;
		if (pending.size() == 0) begin
			$error("unexpected normal word %h degenerate %b", data, user);
			errors++;
			return;
		end
		exp_n = pending.pop_front();
		if (data[15:0] !== exp_n.nx) begin
			$error("nx: expected %h, got %h", exp_n.nx, data[15:0]);
			errors++;
		end
		if (data[31:16] !== exp_n.ny) begin
			$error("ny: expected %h, got %h", exp_n.ny, data[31:16]);
			errors++;
		end
		if (data[47:32] !== exp_n.nz) begin
			$error("nz: expected %h, got %h", exp_n.nz, data[47:32]);
			errors++;
		end
		if (user !== exp_n.degen) begin
			$error("degenerate: expected %b, got %b", exp_n.degen, user);
			errors++;
		end
	endfunction
endclass

module tb_triangle_unit_normal_core;
	localparam int IDLE_LIMIT = 5000;

	logic         clk;
	logic         arst_n;
	logic [143:0] s_tdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [47:0]  m_tdata;
	logic         m_tuser;
	logic         m_tvalid;
	logic         m_tready;

	normal_scoreboard sb;
	int burst_left;
	int idle_cycles;
	int cycle_cnt;

	triangle_unit_normal_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [143:0] pack_triangle(input int ax, ay, az, bx, by_coord, bz,
			cx, cy, cz);
		return {16'(cz), 16'(cy), 16'(cx), 16'(bz), 16'(by_coord), 16'(bx),
			16'(az), 16'(ay), 16'(ax)};
	endfunction

	function automatic int rand_coord();
		return int'(signed'(16'($urandom)));
	endfunction

	// Called at a falling edge; returns at a falling edge.
	task automatic send_triangle(input logic [143:0] word);
		s_tdata <= word;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_triangle(word);
		@(negedge clk);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(0, 40);
		end else begin
			burst_left--;
		end
	endtask

	// Drop valid and hold until every expected normal has come back.
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_triangle();
		int a[3], b[3], c[3], base, sel;
		sel = $urandom_range(0, 99);
		for (int i = 0; i < 3; i++) begin
			a[i] = rand_coord();
			b[i] = rand_coord();
			c[i] = rand_coord();
		end
		if (sel < 20) begin
			// small triangle near a random point
			for (int i = 0; i < 3; i++) begin
				base = $urandom_range(0, 60000) - 30000;
				a[i] = base + $urandom_range(0, 1024) - 512;
				b[i] = base + $urandom_range(0, 1024) - 512;
				c[i] = base + $urandom_range(0, 1024) - 512;
			end
		end else if (sel < 25) begin
			c = a;
		end else if (sel < 28) begin
			b = a;
		end else if (sel < 32) begin
			// collinear: c on the line through a and b
			for (int i = 0; i < 3; i++) begin
				a[i] = $urandom_range(0, 8000) - 4000;
				b[i] = $urandom_range(0, 8000) - 4000;
				c[i] = a[i] + 3 * (b[i] - a[i]);
			end
		end else if (sel < 40) begin
			b[$urandom_range(0, 2)] = a[0];
			c[2] = a[2];
			b[2] = a[2];
		end
		send_triangle(pack_triangle(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2]));
	endtask

	// Receiver: stall pattern steps through four modes, picked by bits 9:8 of cycle_cnt.
	always @(negedge clk) begin
		case ((cycle_cnt >> 8) % 4)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 1) == 1);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ((cycle_cnt % 16) < 11);
		endcase
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_normal(m_tdata, m_tuser);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_triangle_unit_normal_core NOT OK");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		burst_left = 0;
		idle_cycles = 0;
		cycle_cnt = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: degenerate, extremes, axis-aligned normals, ties.
		send_triangle(pack_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_triangle(pack_triangle(-32768, -32768, -32768, 32767, 32767, 32767,
			-32768, -32768, -32768));
		send_triangle(pack_triangle(5, 5, 5, 5, 5, 5, 100, -7, 3));
		send_triangle(pack_triangle(1, 2, 3, 3, 6, 9, 5, 10, 15));
		send_triangle(pack_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0));
		send_triangle(pack_triangle(0, 0, 0, 0, 256, 0, 256, 0, 0));
		send_triangle(pack_triangle(0, 0, 0, 0, 256, 0, 0, 0, 256));
		send_triangle(pack_triangle(0, 0, 0, 0, 0, 256, 256, 0, 0));
		send_triangle(pack_triangle(-32768, -32768, -32768, 32767, -32768, -32768,
			-32768, 32767, -32768));
		send_triangle(pack_triangle(32767, 32767, 32767, -32768, 32767, 32767,
			32767, -32768, 32767));
		send_triangle(pack_triangle(-32768, 0, 32767, 32767, -32768, 0,
			0, 32767, -32768));
		send_triangle(pack_triangle(32767, -32768, 32767, -32768, 32767, -32768,
			32767, 32767, -32768));
		send_triangle(pack_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
		send_triangle(pack_triangle(0, 0, 0, 1, 0, 0, 1, 1, 1));
		send_triangle(pack_triangle(0, 0, 0, 1, 1, 0, 0, 1, 1));
		send_triangle(pack_triangle(-1, -1, -1, 0, 0, 0, 1, 1, 1));
		send_triangle(pack_triangle(32767, 32767, 32767, 32767, 32767, 32767,
			-32768, -32768, -32768));
		send_triangle(pack_triangle(100, 200, 300, -400, 500, -600, 700, -800, 900));
		send_triangle(pack_triangle(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		drain_pipeline();

		for (int i = 0; i < 1100; i++) begin
			send_random_triangle();
			if (i == 500)
				drain_pipeline();
		end
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_triangle_unit_normal_core OK");
		else
			$display("tb_triangle_unit_normal_core NOT OK");
		$finish;
	end
endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/tun_pkg.sv
rtl/tun_front.sv
rtl/tun_div.sv
rtl/tun_isqrt.sv
rtl/triangle_unit_normal_core.sv
verif/tb_triangle_unit_normal_core.sv
